// File: design/wav_riff_chunk_parser_top_defines.svh
// Assertion macros shared by the WAV parser RTL.
// No dependencies; included by the top level.
`ifndef WAV_RIFF_CHUNK_PARSER_TOP_DEFINES_SVH
`define WAV_RIFF_CHUNK_PARSER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define WRP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrp assertion failed");
// next-cycle implication
`define WRP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrp assertion failed");
`else
`define WRP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WRP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/wrp_pkg.sv
// Types and constants of the WAV/RIFF chunk parser.
// No dependencies; used by every module of the parser.
package wrp_pkg;

  localparam int WRP_FIFO_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FMT   = 4'd5,
    PH_SKIP  = 4'd6,
    PH_PAD   = 4'd7,
    PH_DATA  = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [3:0]  TAG_LAST_IDX = 4'd3;   // fourth byte of a tag or size
  localparam logic [3:0]  FMT_LAST_IDX = 4'd15;  // sixteenth fmt field byte
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] PCM_BITS     = 16'd16;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TAG  = 2'd1;
  localparam logic [1:0] ST_BAD_FMT  = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  // what one input byte produced: an optional main word and an optional done word
  typedef struct packed {
    logic               main_valid;
    logic [1:0]         main_kind;
    logic signed [15:0] sample;
    logic               chunk_start;
    logic [1:0]         main_status;
    logic               done_valid;
    logic [1:0]         done_status;
    logic [15:0]        channels;
    logic [31:0]        rate;
  } wrp_event_t;

endpackage

// File: design/wrp_front.sv
// Front end: byte-wise RIFF/WAVE parser, one byte per cycle while take is high.
// Depends on wrp_pkg; emits one event per byte that yields a result.
module wrp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               end_of_file,
  output logic               ev_valid,
  output wrp_pkg::wrp_event_t ev
);
  import wrp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_value, rate_value_next;
  logic [15:0] bits_value, bits_value_next;
  logic        saw_fmt, saw_fmt_next;
  logic        saw_data, saw_data_next;
  logic [7:0]  low_byte, low_byte_next;
  logic        first_word, first_word_next;

  logic [31:0] tag_in;
  logic [31:0] len_in;
  logic [15:0] bits_in;
  logic        tag_end;
  logic        tag_bad;
  logic        fmt_end;
  logic        fmt_bad;
  logic        len_one;

  assign tag_in  = {tag_shift[23:0], in_byte};
  assign len_in  = {in_byte, chunk_length[31:8]};
  assign bits_in = {in_byte, bits_value[7:0]};
  assign tag_end = (cnt == TAG_LAST_IDX);
  assign fmt_end = (cnt == FMT_LAST_IDX);
  assign tag_bad = (phase == PH_RIFF) ? (tag_in != TAG_RIFF) : (tag_in != TAG_WAVE);
  assign fmt_bad = (format_code != FMT_PCM) || (bits_in != PCM_BITS);
  assign len_one = (chunk_length == 32'd1);

  // next state
  always_comb begin
    phase_next         = phase;
    cnt_next           = cnt;
    tag_shift_next     = tag_shift;
    chunk_length_next  = chunk_length;
    format_code_next   = format_code;
    channel_count_next = channel_count;
    rate_value_next    = rate_value;
    bits_value_next    = bits_value;
    saw_fmt_next       = saw_fmt;
    saw_data_next      = saw_data;
    low_byte_next      = low_byte;
    first_word_next    = first_word;
    unique case (phase) inside
      PH_RIFF, PH_WAVE, PH_CID: begin
        tag_shift_next = tag_in;
        cnt_next       = cnt + 4'd1;
        if (tag_end) begin
          cnt_next = '0;
          if (phase == PH_CID) begin
            chunk_length_next = '0;
            phase_next        = PH_CSIZE;
          end else if (tag_bad) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = (phase == PH_RIFF) ? PH_RSIZE : PH_CID;
          end
        end
      end
      PH_RSIZE: begin
        cnt_next = cnt + 4'd1;
        if (tag_end) begin
          cnt_next   = '0;
          phase_next = PH_WAVE;
        end
      end
      PH_CSIZE: begin
        chunk_length_next = len_in;
        cnt_next          = cnt + 4'd1;
        if (tag_end) begin
          cnt_next = '0;
          if (tag_shift == TAG_FMT) begin
            phase_next = PH_FMT;
          end else if (tag_shift == TAG_DATA) begin
            saw_data_next   = 1'b1;
            first_word_next = 1'b1;
            phase_next      = (len_in == '0) ? PH_CID : PH_DATA;
          end else if (len_in != '0) begin
            cnt_next   = {3'b000, len_in[0]};
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_CID;
          end
        end
      end
      PH_FMT: begin
        unique case (cnt)
          4'd0:    format_code_next   = {8'h00, in_byte};
          4'd1:    format_code_next   = {in_byte, format_code[7:0]};
          4'd2:    channel_count_next = {8'h00, in_byte};
          4'd3:    channel_count_next = {in_byte, channel_count[7:0]};
          4'd4:    rate_value_next    = {24'h000000, in_byte};
          4'd5:    rate_value_next    = {16'h0000, in_byte, rate_value[7:0]};
          4'd6:    rate_value_next    = {8'h00, in_byte, rate_value[15:0]};
          4'd7:    rate_value_next    = {in_byte, rate_value[23:0]};
          4'd14:   bits_value_next    = {8'h00, in_byte};
          4'd15:   bits_value_next    = bits_in;
          default: ;
        endcase
        cnt_next = cnt + 4'd1;
        if (fmt_end) begin
          cnt_next = '0;
          if (fmt_bad) begin
            phase_next = PH_DONE;
          end else begin
            saw_fmt_next = 1'b1;
            if (chunk_length > FMT_BODY_LEN) begin
              chunk_length_next = chunk_length - FMT_BODY_LEN;
              cnt_next          = {3'b000, chunk_length[0]};
              phase_next        = PH_SKIP;
            end else begin
              phase_next = PH_CID;
            end
          end
        end
      end
      PH_SKIP: begin
        chunk_length_next = chunk_length - 32'd1;
        if (len_one) begin
          phase_next = (cnt != '0) ? PH_PAD : PH_CID;
          cnt_next   = '0;
        end
      end
      PH_PAD: begin
        cnt_next   = '0;
        phase_next = PH_CID;
      end
      PH_DATA: begin
        chunk_length_next = chunk_length - 32'd1;
        cnt_next          = {3'b000, ~cnt[0]};
        if (!cnt[0]) begin
          low_byte_next = in_byte;
        end else begin
          first_word_next = 1'b0;
        end
        if (len_one) begin
          // odd length ends on a low byte: drop it and skip the pad
          phase_next = cnt[0] ? PH_CID : PH_PAD;
          cnt_next   = '0;
        end
      end
      PH_DONE: ;
      default: phase_next = PH_DONE;
    endcase
  end

  // result event for this byte
  always_comb begin
    ev          = '0;
    ev.channels = channel_count_next;
    ev.rate     = rate_value_next;
    unique case (phase) inside
      PH_RIFF, PH_WAVE: begin
        if (tag_end && tag_bad) begin
          ev.main_valid  = 1'b1;
          ev.main_kind   = KIND_DONE;
          ev.main_status = ST_BAD_TAG;
        end
      end
      PH_FMT: begin
        if (fmt_end) begin
          ev.main_valid  = 1'b1;
          ev.main_kind   = fmt_bad ? KIND_DONE : KIND_FORMAT;
          ev.main_status = fmt_bad ? ST_BAD_FMT : ST_OK;
        end
      end
      PH_DATA: begin
        if (cnt[0]) begin
          ev.main_valid  = 1'b1;
          ev.main_kind   = KIND_SAMPLE;
          ev.sample      = {in_byte, low_byte};
          ev.chunk_start = first_word;
        end
      end
      default: ;
    endcase
    if (end_of_file && (phase_next != PH_DONE)) begin
      ev.done_valid = 1'b1;
      if (phase_next <= PH_WAVE) begin
        ev.done_status = ST_BAD_TAG;
      end else begin
        ev.done_status = (saw_fmt_next && saw_data_next) ? ST_OK : ST_MISSING;
      end
    end
  end

  assign ev_valid = take && (ev.main_valid || ev.done_valid);

  // the final byte of a file puts the parser back to its reset state
  always_ff @(posedge clk) begin
    if (rst || (take && end_of_file)) begin
      phase         <= PH_RIFF;
      cnt           <= '0;
      tag_shift     <= '0;
      chunk_length  <= '0;
      format_code   <= '0;
      channel_count <= '0;
      rate_value    <= '0;
      bits_value    <= '0;
      saw_fmt       <= 1'b0;
      saw_data      <= 1'b0;
      low_byte      <= '0;
      first_word    <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      cnt           <= cnt_next;
      tag_shift     <= tag_shift_next;
      chunk_length  <= chunk_length_next;
      format_code   <= format_code_next;
      channel_count <= channel_count_next;
      rate_value    <= rate_value_next;
      bits_value    <= bits_value_next;
      saw_fmt       <= saw_fmt_next;
      saw_data      <= saw_data_next;
      low_byte      <= low_byte_next;
      first_word    <= first_word_next;
    end
  end

endmodule

// File: design/wrp_fifo.sv
// Short event queue between the parser front end and the output stage.
// Depends on wrp_pkg for the event type and default depth.
module wrp_fifo #(
  parameter int DEPTH = wrp_pkg::WRP_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wrp_pkg::wrp_event_t din,
  input  logic                pop,
  output wrp_pkg::wrp_event_t head,
  output logic                full,
  output logic                empty
);
  import wrp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wrp_event_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: design/wrp_back.sv
// Output stage: expands queued events into result words on the master stream.
// Depends on wrp_pkg; reads the head of wrp_fifo.
module wrp_back (
  input  logic                clk,
  input  logic                rst,
  input  wrp_pkg::wrp_event_t head,
  input  logic                empty,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [71:0]         m_axis_tdata,
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);
  import wrp_pkg::*;

  logic               out_valid;
  logic [1:0]         out_kind;
  logic signed [15:0] out_sample;
  logic               out_start;
  logic [15:0]        out_chans;
  logic [31:0]        out_rate;
  logic [1:0]         out_status;
  logic               out_last;
  logic               sub;       // main word of head already sent

  logic load;
  logic send_main;
  logic take_head;

  assign load      = !out_valid || m_axis_tready;
  assign take_head = load && !empty;
  assign send_main = head.main_valid && !sub;
  assign pop       = take_head && !(send_main && head.done_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (take_head) begin
        sub <= send_main && head.done_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_head) begin
      out_chans <= head.channels;
      out_rate  <= head.rate;
      if (send_main) begin
        out_kind   <= head.main_kind;
        out_sample <= head.sample;
        out_start  <= head.chunk_start;
        out_status <= head.main_status;
        out_last   <= !head.done_valid;
      end else begin
        out_kind   <= KIND_DONE;
        out_sample <= '0;
        out_start  <= 1'b0;
        out_status <= head.done_status;
        out_last   <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000, out_status, out_rate, out_chans, out_start, out_sample};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

// File: design/wav_riff_chunk_parser_top.sv
// WAV/RIFF chunk parser, top level: front parser, event queue, output stage.
// Depends on wrp_pkg, wrp_front, wrp_fifo, wrp_back and the defines header.
//
// Takes a WAV file one byte per word on the slave stream (tlast on the final
// byte) and produces result words on the master stream. The parser accepts a
// byte every cycle; each byte only touches counters and shift registers, so
// the input runs at one byte per clock as long as the four-entry event queue
// has room. Output words leave one per clock while m_axis_tready is high: a
// byte normally yields none or one word, and the final byte may yield two (a
// sample or format report, then the done word), which the output stage sends
// one after the other. An accepted byte's first word reaches the master side
// through the queue write and then the output register. Words carry kind in
// tuser: sample, format found, or done/error; a done word always has tlast set
// and is the last word of its file; the final byte of a file puts the parser
// back in its reset state for the next file. Errors (bad RIFF/WAVE tag,
// format other than 16-bit PCM) are reported at once, and the remaining bytes
// of that file are swallowed. Odd chunks, data chunks included, are followed
// by a skipped pad byte; the unpaired last byte of an odd data chunk is
// dropped. No memory clearing is needed after reset.
module wav_riff_chunk_parser_top #(
  parameter int FIFO_DEPTH = wrp_pkg::WRP_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] sample, [16] chunk_start,
                                      // [32:17] channel count, [64:33] rate,
                                      // [66:65] status, [71:67] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last word for this byte
);
  import wrp_pkg::*;

`include "wav_riff_chunk_parser_top_defines.svh"

  logic       take;
  logic       ev_valid;
  wrp_event_t ev;
  wrp_event_t head;
  logic       q_full;
  logic       q_empty;
  logic       pop;

  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  wrp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (s_axis_tdata),
    .end_of_file (s_axis_tlast),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  wrp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_valid),
    .din   (ev),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  wrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // sample words never carry a status code
  `WRP_ASSERT_IMP(a_sample_status_ok, clk, rst,
    m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE), m_axis_tdata[66:65] == ST_OK)
  // chunk_start only marks samples
  `WRP_ASSERT_IMP(a_start_on_sample, clk, rst,
    m_axis_tvalid && m_axis_tdata[16], m_axis_tuser == KIND_SAMPLE)
  // a done word always closes its byte
  `WRP_ASSERT_IMP(a_done_is_last, clk, rst,
    m_axis_tvalid && (m_axis_tuser == KIND_DONE), m_axis_tlast)
  // a word without tlast is followed at once by its done word
  `WRP_ASSERT_NXT(a_done_follows, clk, rst,
    m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && (m_axis_tuser == KIND_DONE))

endmodule
